@@ sv/tmsr_pkg.sv @@
`timescale 1ns / 1ps

package tmsr_pkg;

    localparam int TILE_COUNT       = 384;
    localparam int MAP_COLUMN_COUNT = 32;
    localparam int MAP_ROWS         = 32;
    localparam int TILE_SIDE        = 8;
    localparam int TILE_BYTES       = 16;
    localparam int MAX_LINE_PIXELS  = 256;
    localparam int MAP_DEPTH        = MAP_ROWS * MAP_COLUMN_COUNT;
    localparam int TILE_DEPTH       = TILE_COUNT * TILE_BYTES;
    localparam int PLANE_DEPTH      = TILE_DEPTH / 2;
    localparam int QUEUE_DEPTH      = 2;

    localparam int MAP_AW   = $clog2(MAP_DEPTH);
    localparam int PLANE_AW = $clog2(PLANE_DEPTH);
    localparam int Q_AW     = $clog2(QUEUE_DEPTH);
    localparam int Q_CW     = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic REG_ID_MODE = 1'b0;
    localparam logic REG_PALETTE = 1'b1;

    typedef enum logic [1:0] {
        CMD_MAP_WR  = 2'd0,
        CMD_TILE_WR = 2'd1,
        CMD_DRAW    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAP,
        ST_TILE,
        ST_PIX
    } back_state_t;

    typedef struct packed {
        cmd_t        op;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [4:0]  row;
        logic [4:0]  col;
        logic [2:0]  fine_x;
        logic [2:0]  fine_y;
        logic [8:0]  count;
    } job_t;

endpackage

@@ sv/tmsr_if.sv @@
`timescale 1ns / 1ps

interface tmsr_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [12:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  start_x;
    logic [7:0]  start_y;
    logic [8:0]  pixel_count;

    modport source (output valid, command, write_address, write_data, start_x, start_y,
                    pixel_count, input ready);
    modport sink (input valid, command, write_address, write_data, start_x, start_y,
                  pixel_count, output ready);
endinterface

interface tmsr_seg_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_0;
    logic [7:0] pixel_1;
    logic [7:0] pixel_2;
    logic [7:0] pixel_3;
    logic [7:0] pixel_4;
    logic [7:0] pixel_5;
    logic [7:0] pixel_6;
    logic [7:0] pixel_7;
    logic [3:0] valid_pixels;
    logic       last_of_line;

    modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                    pixel_6, pixel_7, valid_pixels, last_of_line, input ready);
    modport sink (input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                  pixel_6, pixel_7, valid_pixels, last_of_line, output ready);
endinterface

@@ sv/tmsr_ram.sv @@
`timescale 1ns / 1ps

module tmsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/tmsr_front.sv @@
`timescale 1ns / 1ps

module tmsr_front
    import tmsr_pkg::*;
(
    tmsr_cmd_if.sink   cmd,
    input  logic       q_full,
    output logic       push,
    output job_t       job
);

    logic accept;
    logic keep;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;

    // drop out-of-range writes, empty draws and unknown commands here
    always_comb
    begin
        keep = 1'b0;
        unique case (cmd.command)
            CMD_MAP_WR:
            begin
                keep = cmd.write_address < 13'(MAP_DEPTH);
            end
            CMD_TILE_WR:
            begin
                keep = cmd.write_address < 13'(TILE_DEPTH);
            end
            CMD_DRAW:
            begin
                keep = cmd.pixel_count != 9'd0;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = accept && keep;

    always_comb
    begin
        job.op     = cmd_t'(cmd.command);
        job.addr   = cmd.write_address;
        job.data   = cmd.write_data;
        job.row    = cmd.start_y[7:3];
        job.col    = cmd.start_x[7:3];
        job.fine_x = cmd.start_x[2:0];
        job.fine_y = cmd.start_y[2:0];
        job.count  = (cmd.pixel_count > 9'(MAX_LINE_PIXELS)) ? 9'(MAX_LINE_PIXELS)
                                                             : cmd.pixel_count;
    end

endmodule

@@ sv/tmsr_queue.sv @@
`timescale 1ns / 1ps

module tmsr_queue
    import tmsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output job_t head
);

    job_t            slot_reg [QUEUE_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic [Q_CW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = count_reg == Q_CW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

@@ sv/tmsr_back.sv @@
`timescale 1ns / 1ps

module tmsr_back
    import tmsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        job,
    input  logic        job_valid,
    output logic        job_pop,
    input  logic        ids_signed,
    input  logic [31:0] palette,
    tmsr_seg_if.source  seg
);

    back_state_t state_reg;
    back_state_t state_next;

    logic [4:0] row_reg;
    logic [4:0] col_reg;
    logic [2:0] fine_x_reg;
    logic [2:0] fine_y_reg;
    logic [8:0] remaining_reg;

    logic       out_valid_reg;
    logic [7:0] pix_reg [8];
    logic [3:0] num_reg;
    logic       last_reg;

    logic map_we;
    logic tile_we;
    logic map_re;
    logic tile_re;
    logic seg_load;
    logic start_draw;

    logic [7:0]          map_rdata;
    logic [7:0]          lo_rdata;
    logic [7:0]          hi_rdata;
    logic [8:0]          tile_num;
    logic [PLANE_AW-1:0] tile_raddr;

    logic [3:0] avail;
    logic [3:0] num;
    logic       last;
    logic [7:0] lo_shift;
    logic [7:0] hi_shift;
    logic [1:0] color_idx [8];
    logic [7:0] pix [8];

    tmsr_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (job.addr[MAP_AW-1:0]),
        .wdata (job.data),
        .re    (map_re),
        .raddr ({row_reg, col_reg}),
        .rdata (map_rdata)
    );

    // plane 0 holds the low bitplane bytes, plane 1 the high ones
    tmsr_ram #(.WIDTH(8), .DEPTH(PLANE_DEPTH)) u_lo_ram (
        .clk   (clk),
        .we    (tile_we && !job.addr[0]),
        .waddr (job.addr[PLANE_AW:1]),
        .wdata (job.data),
        .re    (tile_re),
        .raddr (tile_raddr),
        .rdata (lo_rdata)
    );

    tmsr_ram #(.WIDTH(8), .DEPTH(PLANE_DEPTH)) u_hi_ram (
        .clk   (clk),
        .we    (tile_we && job.addr[0]),
        .waddr (job.addr[PLANE_AW:1]),
        .wdata (job.data),
        .re    (tile_re),
        .raddr (tile_raddr),
        .rdata (hi_rdata)
    );

    // signed ids: 0..127 map to tiles 256..383, 128..255 stay as they are
    assign tile_num   = {ids_signed && !map_rdata[7], map_rdata};
    assign tile_raddr = {tile_num, fine_y_reg};

    assign avail = 4'(TILE_SIDE) - {1'b0, fine_x_reg};
    assign num   = (remaining_reg < {5'd0, avail}) ? remaining_reg[3:0] : avail;
    assign last  = remaining_reg == {5'd0, num};

    assign lo_shift = lo_rdata << fine_x_reg;
    assign hi_shift = hi_rdata << fine_x_reg;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            color_idx[k] = {hi_shift[7-k], lo_shift[7-k]};
            pix[k]       = (4'(k) < num) ? palette[{color_idx[k], 3'b000} +: 8] : 8'd0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && job.op == CMD_DRAW)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                state_next = ST_TILE;
            end
            ST_TILE:
            begin
                state_next = ST_PIX;
            end
            ST_PIX:
            begin
                if (seg_load)
                begin
                    state_next = last ? ST_IDLE : ST_MAP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        job_pop    = 1'b0;
        map_we     = 1'b0;
        tile_we    = 1'b0;
        map_re     = 1'b0;
        tile_re    = 1'b0;
        seg_load   = 1'b0;
        start_draw = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                job_pop    = job_valid;
                map_we     = job_valid && job.op == CMD_MAP_WR;
                tile_we    = job_valid && job.op == CMD_TILE_WR;
                start_draw = job_valid && job.op == CMD_DRAW;
            end
            ST_MAP:
            begin
                map_re = 1'b1;
            end
            ST_TILE:
            begin
                tile_re = 1'b1;
            end
            ST_PIX:
            begin
                // hold the tile bytes until the output register frees up
                seg_load = !out_valid_reg || seg.ready;
            end
            default:
            begin
                job_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (seg_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (seg.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_draw)
        begin
            row_reg       <= job.row;
            col_reg       <= job.col;
            fine_x_reg    <= job.fine_x;
            fine_y_reg    <= job.fine_y;
            remaining_reg <= job.count;
        end
        else if (seg_load)
        begin
            // advance to the next tile column, wrapping at the map edge
            col_reg       <= col_reg + 5'd1;
            fine_x_reg    <= 3'd0;
            remaining_reg <= remaining_reg - {5'd0, num};
        end
        if (seg_load)
        begin
            pix_reg  <= pix;
            num_reg  <= num;
            last_reg <= last;
        end
    end

    assign seg.valid        = out_valid_reg;
    assign seg.pixel_0      = pix_reg[0];
    assign seg.pixel_1      = pix_reg[1];
    assign seg.pixel_2      = pix_reg[2];
    assign seg.pixel_3      = pix_reg[3];
    assign seg.pixel_4      = pix_reg[4];
    assign seg.pixel_5      = pix_reg[5];
    assign seg.pixel_6      = pix_reg[6];
    assign seg.pixel_7      = pix_reg[7];
    assign seg.valid_pixels = num_reg;
    assign seg.last_of_line = last_reg;

endmodule

@@ sv/tile_map_scanline_renderer.sv @@
`timescale 1ns / 1ps
// Channel   Modport  Moves                          Accepted when
// cmd       sink     one request (write or draw)    cmd.valid && cmd.ready
// seg       source   one tile segment of a line     seg.valid && seg.ready
// cfg       write    signed ids, palette            cfg_write high
//
// The back end performs a write request from its idle state. A draw goes through map read,
// tile plane read and pixel decode for each of its N tile segments (up to 33), the steps
// set by the registered read ports of the map and tile memories.
// A two-entry queue lets the front accept requests while the back end works.
// A full output register with seg.ready low holds the back end in pixel decode.
// Reset clears control and configuration; memory contents are undefined until written.

module tile_map_scanline_renderer
    import tmsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    tmsr_cmd_if.sink    cmd,
    tmsr_seg_if.source  seg
);

    logic        ids_signed_reg;
    logic [31:0] palette_reg;

    logic q_full;
    logic push;
    job_t push_job;
    logic pop;
    logic q_not_empty;
    job_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ids_signed_reg <= 1'b0;
            palette_reg    <= 32'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ID_MODE: ids_signed_reg <= cfg_data[0];
                REG_PALETTE: palette_reg    <= cfg_data;
                default:     palette_reg    <= palette_reg;
            endcase
        end
    end

    tmsr_front u_front (
        .cmd    (cmd),
        .q_full (q_full),
        .push   (push),
        .job    (push_job)
    );

    tmsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head)
    );

    tmsr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (head),
        .job_valid  (q_not_empty),
        .job_pop    (pop),
        .ids_signed (ids_signed_reg),
        .palette    (palette_reg),
        .seg        (seg)
    );

endmodule

@@ test/tb_tile_map_scanline_renderer.sv @@
`timescale 1ns / 1ps

module tb_tile_map_scanline_renderer;
    import tmsr_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int DRAIN_CYCLES = 160;
    localparam int PHASE_ITEMS  = 45;
    localparam int PHASES       = 6;
    localparam int HOLD_CYCLES  = 600;

    typedef enum logic { STEP_REQ, STEP_REG } step_kind_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [8:0]  count;
    } req_t;

    typedef struct packed {
        logic [0:7][7:0] pix;
        logic [3:0]      npix;
        logic            last;
    } seg_t;

    typedef struct packed {
        step_kind_t kind;
        logic       reg_idx;
        logic [31:0] reg_val;
        req_t       req;
        logic       typed;
        seg_t       want;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [31:0] cfg_data;

    tmsr_cmd_if cmd_bus ();
    tmsr_seg_if seg_bus ();

    tile_map_scanline_renderer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .seg       (seg_bus)
    );

    always #4 clk = ~clk;

    // shadow of the block's stores and registers
    logic [7:0]  map_mirror  [MAP_DEPTH];
    bit          map_set     [MAP_DEPTH];
    logic [7:0]  tile_mirror [TILE_DEPTH];
    bit          tile_set    [TILE_DEPTH];
    logic        ids_signed = 1'b0;
    logic [31:0] palette = 32'd0;

    seg_t segs_due [$];
    seg_t seen_seg;
    seg_t due_seg;
    logic [7:0] pix_bad;

    int errors = 0;
    int reqs_sent = 0;
    int draws = 0;
    int segs_seen = 0;
    int reg_writes = 0;
    int hold_asks = 0;
    bit quiet = 1'b0;

    function automatic int tile_of(logic [7:0] id);
        if (ids_signed)
            return id[7] ? int'(id) : 256 + int'(id);
        return int'(id);
    endfunction

    function automatic void predict_line(logic [7:0] x, logic [7:0] y, logic [8:0] n);
        int left, row, col, fx, fy, num, k, tnum, base, ci;
        logic [7:0] lo, hi;
        seg_t s;
        left = (n > MAX_LINE_PIXELS) ? MAX_LINE_PIXELS : int'(n);
        row  = int'(y) / TILE_SIDE;
        col  = int'(x) / TILE_SIDE;
        fx   = int'(x) % TILE_SIDE;
        fy   = int'(y) % TILE_SIDE;
        while (left > 0) begin
            tnum = tile_of(map_mirror[row * MAP_COLUMN_COUNT + col]);
            base = tnum * TILE_BYTES + fy * 2;
            lo   = tile_mirror[base];
            hi   = tile_mirror[base + 1];
            num  = TILE_SIDE - fx;
            if (num > left)
                num = left;
            s = '0;
            for (k = 0; k < num; k++) begin
                ci = {hi[7 - fx - k], lo[7 - fx - k]};
                s.pix[k] = palette[8 * ci +: 8];
            end
            left   -= num;
            s.npix  = 4'(num);
            s.last  = (left == 0);
            segs_due.push_back(s);
            fx  = 0;
            col = (col + 1) % MAP_COLUMN_COUNT;
        end
    endfunction

    function automatic req_t wr_req(logic [1:0] op, logic [12:0] addr, logic [7:0] data);
        req_t r;
        r.op    = op;
        r.addr  = addr;
        r.data  = data;
        r.x     = 8'($urandom_range(255));
        r.y     = 8'($urandom_range(255));
        r.count = 9'($urandom_range(511));
        return r;
    endfunction

    function automatic req_t draw_req(logic [7:0] x, logic [7:0] y, logic [8:0] n);
        req_t r;
        r.op    = CMD_DRAW;
        r.addr  = 13'($urandom_range(8191));
        r.data  = 8'($urandom_range(255));
        r.x     = x;
        r.y     = y;
        r.count = n;
        return r;
    endfunction

    function automatic step_t dir_write(logic [1:0] op, logic [12:0] addr, logic [7:0] data);
        step_t s;
        s = '0;
        s.kind = STEP_REQ;
        s.req  = wr_req(op, addr, data);
        return s;
    endfunction

    function automatic step_t dir_draw(logic [7:0] x, logic [7:0] y, logic [8:0] n);
        step_t s;
        s = '0;
        s.kind = STEP_REQ;
        s.req  = draw_req(x, y, n);
        return s;
    endfunction

    function automatic step_t dir_draw_seg(logic [7:0] x, logic [7:0] y, logic [8:0] n,
                                           logic [0:7][7:0] pix, logic [3:0] npix,
                                           logic last);
        step_t s;
        s = dir_draw(x, y, n);
        s.typed     = 1'b1;
        s.want.pix  = pix;
        s.want.npix = npix;
        s.want.last = last;
        return s;
    endfunction

    function automatic step_t dir_reg(logic idx, logic [31:0] val);
        step_t s;
        s = '0;
        s.kind    = STEP_REG;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    function automatic int rand_count();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 0;
        if (pick < 70)
            return $urandom_range(24, 1);
        if (pick < 88)
            return $urandom_range(256, 25);
        return $urandom_range(511, 257);
    endfunction

    task automatic send_req(input req_t r, input logic typed, input seg_t want);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(99) < 29)
                gap++;
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.command       <= r.op;
        cmd_bus.write_address <= r.addr;
        cmd_bus.write_data    <= r.data;
        cmd_bus.start_x       <= r.x;
        cmd_bus.start_y       <= r.y;
        cmd_bus.pixel_count   <= r.count;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        reqs_sent++;
        case (r.op)
            CMD_MAP_WR:
                if (r.addr < MAP_DEPTH) begin
                    map_mirror[r.addr] = r.data;
                    map_set[r.addr]    = 1'b1;
                end
            CMD_TILE_WR:
                if (r.addr < TILE_DEPTH) begin
                    tile_mirror[r.addr] = r.data;
                    tile_set[r.addr]    = 1'b1;
                end
            CMD_DRAW: begin
                draws++;
                if (typed)
                    segs_due.push_back(want);
                else
                    predict_line(r.x, r.y, r.count);
            end
            default: ;
        endcase
    endtask

    // fill in any map entry or tile line the draw would read before it was written
    task automatic line_draw(input int x, input int y, input int n);
        int left, row, col, fx, fy, num, base, a;
        left = (n > MAX_LINE_PIXELS) ? MAX_LINE_PIXELS : n;
        row  = y / TILE_SIDE;
        col  = x / TILE_SIDE;
        fx   = x % TILE_SIDE;
        fy   = y % TILE_SIDE;
        while (left > 0) begin
            a = row * MAP_COLUMN_COUNT + col;
            if (!map_set[a])
                send_req(wr_req(CMD_MAP_WR, 13'(a), 8'($urandom_range(255))), 1'b0, '0);
            base = tile_of(map_mirror[a]) * TILE_BYTES + fy * 2;
            if (!tile_set[base])
                send_req(wr_req(CMD_TILE_WR, 13'(base), 8'($urandom_range(255))), 1'b0, '0);
            if (!tile_set[base + 1])
                send_req(wr_req(CMD_TILE_WR, 13'(base + 1), 8'($urandom_range(255))), 1'b0,
                         '0);
            num = TILE_SIDE - fx;
            if (num > left)
                num = left;
            left -= num;
            fx  = 0;
            col = (col + 1) % MAP_COLUMN_COUNT;
        end
        send_req(draw_req(8'(x), 8'(y), 9'(n)), 1'b0, '0);
    endtask

    task automatic settle();
        cmd_bus.valid <= 1'b0;
        while (segs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        settle();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_ID_MODE)
            ids_signed = val[0];
        else
            palette = val;
        reg_writes++;
    endtask

    // receiver: random stalls, a long hold-off on request, quiet stretches
    initial
    begin
        int hold_left;
        int served;
        hold_left     = 0;
        served        = 0;
        seg_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (served < hold_asks) begin
                served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                seg_bus.ready <= 1'b0;
            end
            else if (quiet)
                seg_bus.ready <= 1'b1;
            else
                seg_bus.ready <= ($urandom_range(99) >= 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && seg_bus.valid && seg_bus.ready) begin
            seen_seg = {seg_bus.pixel_0, seg_bus.pixel_1, seg_bus.pixel_2, seg_bus.pixel_3,
                        seg_bus.pixel_4, seg_bus.pixel_5, seg_bus.pixel_6, seg_bus.pixel_7,
                        seg_bus.valid_pixels, seg_bus.last_of_line};
            segs_seen++;
            if (segs_due.size() == 0) begin
                errors++;
                $display("%0t ns: segment with nothing due: expected none, got %h", $time,
                         seen_seg);
            end
            else begin
                due_seg = segs_due.pop_front();
                for (int k = 0; k < 8; k++)
                    pix_bad[7 - k] = (seen_seg.pix[k] !== due_seg.pix[k]);
                if (pix_bad != 8'd0) begin
                    errors++;
                    $display("%0t ns: pixel fields %b (pixel_0 first) expected %h got %h",
                             $time, pix_bad, due_seg.pix, seen_seg.pix);
                end
                if (seen_seg.npix !== due_seg.npix) begin
                    errors++;
                    $display("%0t ns: valid_pixels expected %0d got %0d", $time,
                             due_seg.npix, seen_seg.npix);
                end
                if (seen_seg.last !== due_seg.last) begin
                    errors++;
                    $display("%0t ns: last_of_line expected %0d got %0d", $time,
                             due_seg.last, seen_seg.last);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("%0t ns: run did not finish in time", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        step_t steps [$];
        logic [31:0] pal_set [PHASES];
        int ph;
        int first;
        int pick;

        rst_n                 = 1'b0;
        cfg_write             = 1'b0;
        cfg_index             = 1'b0;
        cfg_data              = 32'd0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.command       = 2'd0;
        cmd_bus.write_address = 13'd0;
        cmd_bus.write_data    = 8'd0;
        cmd_bus.start_x       = 8'd0;
        cmd_bus.start_y       = 8'd0;
        cmd_bus.pixel_count   = 9'd0;

        steps.push_back(dir_write(CMD_MAP_WR, 13'd0, 8'h00));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd0, 8'hF0));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd1, 8'hCC));
        steps.push_back(dir_draw(8'd0, 8'd0, 9'd0));
        // palette still all zero after reset
        steps.push_back(dir_draw_seg(8'd0, 8'd0, 9'd8, 64'h00_00_00_00_00_00_00_00, 4'd8,
                                     1'b1));
        steps.push_back(dir_reg(REG_PALETTE, 32'h03_02_01_00));
        steps.push_back(dir_draw_seg(8'd0, 8'd0, 9'd8, 64'h03_03_01_01_02_02_00_00, 4'd8,
                                     1'b1));
        steps.push_back(dir_draw_seg(8'd5, 8'd0, 9'd2, 64'h02_00_00_00_00_00_00_00, 4'd2,
                                     1'b1));
        steps.push_back(dir_write(CMD_MAP_WR, 13'd1023, 8'hFF));
        steps.push_back(dir_write(CMD_MAP_WR, 13'h1FFF, 8'hFF));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd4094, 8'h81));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd4095, 8'h01));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd6143, 8'hFF));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd6144, 8'h00));
        steps.push_back(dir_write(CMD_RESERVED, 13'h1FFF, 8'hFF));
        steps.push_back(dir_draw_seg(8'd255, 8'd255, 9'd1, 64'h03_00_00_00_00_00_00_00, 4'd1,
                                     1'b1));
        steps.push_back(dir_write(CMD_MAP_WR, 13'd992, 8'h80));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd2062, 8'h55));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd2063, 8'hAA));
        // wraps from the last map column back to column zero
        steps.push_back(dir_draw(8'd255, 8'd255, 9'd2));
        steps.push_back(dir_reg(REG_ID_MODE, 32'd1));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd4096, 8'h3C));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd4097, 8'hFF));
        steps.push_back(dir_write(CMD_MAP_WR, 13'd1, 8'h7F));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd6128, 8'hA5));
        steps.push_back(dir_write(CMD_TILE_WR, 13'd6129, 8'h5A));
        steps.push_back(dir_draw(8'd4, 8'd0, 9'd12));

        pal_set[0] = $urandom();
        pal_set[1] = 32'hFFFF_FFFF;
        pal_set[2] = 32'h0000_0000;
        pal_set[3] = $urandom();
        pal_set[4] = 32'hFFFF_FFFF;
        pal_set[5] = $urandom();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i]) begin
            if (steps[i].kind == STEP_REG)
                write_reg(steps[i].reg_idx, steps[i].reg_val);
            else
                send_req(steps[i].req, steps[i].typed, steps[i].want);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_ID_MODE, 32'(ph % 2));
            write_reg(REG_PALETTE, pal_set[ph]);
            // stall the output long enough to back up the request path
            if (ph == 1)
                hold_asks++;
            quiet = (ph == 3);
            first = reqs_sent;
            while (reqs_sent - first < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 45)
                    line_draw($urandom_range(255), $urandom_range(255), rand_count());
                else if (pick < 70)
                    send_req(wr_req(CMD_TILE_WR, 13'($urandom_range(TILE_DEPTH - 1)),
                                    8'($urandom_range(255))), 1'b0, '0);
                else if (pick < 82)
                    send_req(wr_req(CMD_MAP_WR, 13'($urandom_range(MAP_DEPTH - 1)),
                                    8'($urandom_range(255))), 1'b0, '0);
                else if (pick < 88)
                    send_req(wr_req(CMD_MAP_WR, 13'($urandom_range(8191, MAP_DEPTH)),
                                    8'($urandom_range(255))), 1'b0, '0);
                else if (pick < 93)
                    send_req(wr_req(CMD_TILE_WR, 13'($urandom_range(8191, TILE_DEPTH)),
                                    8'($urandom_range(255))), 1'b0, '0);
                else
                    send_req(wr_req(CMD_RESERVED, 13'($urandom_range(8191)),
                                    8'($urandom_range(255))), 1'b0, '0);
            end
            quiet = 1'b0;
        end

        settle();

        $display("Sent %0d requests, %0d of them draws; checked %0d tile segments", reqs_sent,
                 draws, segs_seen);
        $display("across %0d register writes, including a long output stall", reg_writes);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
